/* hdl/brfc_pkg.sv */
`default_nettype none
package brfc_pkg;
    localparam int MAX_LEARNERS     = 256;
    localparam int MAX_RECTS        = 4;
    localparam int SAMPLE_POSITIONS = 1024;
    localparam int LW  = $clog2(MAX_LEARNERS);
    localparam int RW  = $clog2(MAX_RECTS);
    localparam int PW  = $clog2(SAMPLE_POSITIONS);
    localparam int RCW = $clog2(MAX_RECTS + 1);
    localparam int CNTW = $clog2(MAX_LEARNERS + 1);

    typedef enum logic [1:0] {
        OP_LOAD_RECT    = 2'd0,
        OP_LOAD_LEARNER = 2'd1,
        OP_LOAD_SAMPLE  = 2'd2,
        OP_EVALUATE     = 2'd3
    } t_op;
endpackage
`default_nettype wire

/* hdl/brfc_datapath.sv */
`default_nettype none
// Shared arithmetic unit: corner combine, one rectangle multiply, accumulate
module brfc_datapath (
    input  wire logic        i_clk,
    input  wire logic        i_clr_box,
    input  wire logic        i_add_box,
    input  wire logic        i_sub_box,
    input  wire logic [31:0] i_sample,
    input  wire logic        i_mul,
    input  wire logic signed [7:0] i_weight,
    input  wire logic        i_clr_acc,
    output logic signed [47:0] o_acc
);
    logic signed [33:0] r_box;
    logic signed [47:0] r_acc;
    logic signed [33:0] w_s;

    assign w_s = 34'(signed'(i_sample));

    // Combine corners, then weight and accumulate
    always_ff @(posedge i_clk) begin
        if (i_clr_box)      r_box <= '0;
        else if (i_add_box) r_box <= r_box + w_s;
        else if (i_sub_box) r_box <= r_box - w_s;
        if (i_clr_acc)      r_acc <= '0;
        else if (i_mul)     r_acc <= r_acc + 48'(r_box * 34'(i_weight));
    end
    assign o_acc = r_acc;
endmodule
`default_nettype wire

/* hdl/boosted_rectangle_feature_classifier.sv */
`default_nettype none
// Loads can follow back to back. An evaluate walks each learner in use through its
// rectangles and then its vote before raising its result: a rectangle costs four reads
// of the sample memory, a fill, a drain and a multiply step.
// The result register holds a value until taken while loads may still be accepted; a
// finished evaluate waits in its output state until that register is free.
// Synchronous active-low reset clears control and learners_in_use; tables are not cleared.
module boosted_rectangle_feature_classifier (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [1:0]  i_operation,
    input  wire logic [7:0]  i_learner,
    input  wire logic [1:0]  i_slot,
    input  wire logic [9:0]  i_corner_a,
    input  wire logic [9:0]  i_corner_b,
    input  wire logic [9:0]  i_corner_c,
    input  wire logic [9:0]  i_corner_d,
    input  wire logic signed [7:0]  i_rect_weight,
    input  wire logic signed [31:0] i_data_value,
    input  wire logic        i_polarity,
    input  wire logic [2:0]  i_rect_count,
    input  wire logic signed [15:0] i_learner_weight,
    input  wire logic        i_cfg_we,
    input  wire logic [8:0]  i_cfg_data,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic signed [31:0] o_vote_sum
);
    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_LRN   = 9'b000000010,
        S_LWAIT = 9'b000000100,
        S_RECT  = 9'b000001000,
        S_RWAIT = 9'b000010000,
        S_CORN  = 9'b000100000,
        S_MUL   = 9'b001000000,
        S_VOTE  = 9'b010000000,
        S_OUT   = 9'b100000000
    } t_state;

    // Memories
    logic [31:0] r_sample_mem [brfc_pkg::SAMPLE_POSITIONS];
    logic [39:0] r_corner_mem [brfc_pkg::MAX_LEARNERS*brfc_pkg::MAX_RECTS];
    logic [7:0]  r_rw_mem     [brfc_pkg::MAX_LEARNERS*brfc_pkg::MAX_RECTS];
    logic [51:0] r_lrn_mem    [brfc_pkg::MAX_LEARNERS];

    t_state r_state, n_state;
    logic [8:0]  r_cfg;
    logic [brfc_pkg::CNTW-1:0] r_k;
    logic [brfc_pkg::RCW-1:0]  r_j, r_n;
    logic [2:0]  r_c;
    logic [39:0] r_corner_q;
    logic [7:0]  r_rw_q;
    logic [51:0] r_lrn_q;
    logic [31:0] r_samp_q;
    logic        r_samp_ok;
    logic [39:0] r_corners;
    logic        r_cpend, r_csign;
    logic signed [47:0] r_total;
    logic        r_ovalid;
    logic signed [31:0] r_out;
    logic [brfc_pkg::CNTW-1:0] w_lim;
    logic        w_acc_in;
    logic        w_out_hold;
    logic signed [47:0] w_acc;
    logic [brfc_pkg::PW-1:0] w_pos;
    logic        w_below, w_plus;
    logic [2:0]  w_rc;
    logic signed [47:0] w_lw;

    assign o_ready = (r_state == S_IDLE);
    assign w_acc_in = i_valid && o_ready;
    // A result still waiting holds the finished evaluate in its output state
    assign w_out_hold = r_ovalid && !i_ready;
    assign w_lim = (r_cfg > 9'(brfc_pkg::MAX_LEARNERS)) ?
                   brfc_pkg::CNTW'(brfc_pkg::MAX_LEARNERS) : brfc_pkg::CNTW'(r_cfg);

    // Table writes and registered reads
    always_ff @(posedge i_clk) begin
        if (w_acc_in && i_operation == brfc_pkg::OP_LOAD_RECT) begin
            r_corner_mem[{i_learner, i_slot}] <= {i_corner_d, i_corner_c, i_corner_b, i_corner_a};
            r_rw_mem[{i_learner, i_slot}]     <= i_rect_weight;
        end
        if (w_acc_in && i_operation == brfc_pkg::OP_LOAD_LEARNER)
            r_lrn_mem[i_learner] <= {i_learner_weight, i_polarity, i_rect_count, i_data_value};
        if (w_acc_in && i_operation == brfc_pkg::OP_LOAD_SAMPLE)
            r_sample_mem[i_corner_a] <= i_data_value;
        r_corner_q <= r_corner_mem[{r_k[brfc_pkg::LW-1:0], r_j[brfc_pkg::RW-1:0]}];
        r_rw_q     <= r_rw_mem[{r_k[brfc_pkg::LW-1:0], r_j[brfc_pkg::RW-1:0]}];
        r_lrn_q    <= r_lrn_mem[r_k[brfc_pkg::LW-1:0]];
        r_samp_q   <= r_sample_mem[w_pos];
    end

    // Corner being read: shift through a, b, c, d
    assign w_pos = r_corners[9:0];

    brfc_datapath u_dp (
        .i_clk     (i_clk),
        .i_clr_box (r_state == S_RWAIT),
        .i_add_box (r_cpend && !r_csign),
        .i_sub_box (r_cpend && r_csign),
        .i_sample  (r_samp_ok ? r_samp_q : 32'd0),
        .i_mul     (r_state == S_MUL),
        .i_weight  (signed'(r_rw_q)),
        .i_clr_acc (r_state == S_LWAIT),
        .o_acc     (w_acc)
    );

    assign w_below = w_acc < 48'(signed'(r_lrn_q[31:0]));
    assign w_plus  = r_lrn_q[35] ? w_below : !w_below;
    assign w_rc    = r_lrn_q[34:32];
    assign w_lw    = 48'(signed'(r_lrn_q[51:36]));

    // Sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (w_acc_in && i_operation == brfc_pkg::OP_EVALUATE)
                         n_state = (w_lim == '0) ? S_OUT : S_LRN;
            S_LRN:   n_state = S_LWAIT;
            S_LWAIT: n_state = S_RECT;
            S_RECT:  n_state = (r_j == r_n) ? S_VOTE : S_RWAIT;
            S_RWAIT: n_state = S_CORN;
            S_CORN:  n_state = (r_c == 3'd5) ? S_MUL : S_CORN;
            S_MUL:   n_state = S_RECT;
            S_VOTE:  n_state = (r_k + 1'b1 == w_lim) ? S_OUT : S_LRN;
            S_OUT:   n_state = w_out_hold ? S_OUT : S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cfg    <= '0;
            r_ovalid <= 1'b0;
            r_cpend  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) r_cfg <= i_cfg_data;
            if (r_state == S_OUT && !w_out_hold) r_ovalid <= 1'b1;
            else if (i_ready) r_ovalid <= 1'b0;
            r_cpend <= (r_state == S_CORN) && (r_c < 3'd4);
        end
        // Register sample read qualifiers so they arrive in the cycle after the address
        r_samp_ok <= 1'b1;
        r_csign   <= (r_c == 3'd1) || (r_c == 3'd2);
        unique case (r_state)
            S_IDLE: begin
                r_k <= '0;
                r_total <= '0;
            end
            S_LWAIT: begin
                r_j <= '0;
                r_n <= (w_rc > 3'(brfc_pkg::MAX_RECTS)) ?
                       brfc_pkg::RCW'(brfc_pkg::MAX_RECTS) : brfc_pkg::RCW'(w_rc);
            end
            S_RWAIT: begin
                r_corners <= r_corner_q;
                r_c <= '0;
            end
            S_CORN: begin
                r_corners <= {10'd0, r_corners[39:10]};
                r_c <= r_c + 3'd1;
            end
            S_MUL: r_j <= r_j + 1'b1;
            S_VOTE: begin
                r_total <= w_plus ? r_total + w_lw : r_total - w_lw;
                r_k <= r_k + 1'b1;
            end
            S_OUT: begin
                if (!w_out_hold) begin
                    if (r_total > 48'sd2147483647) r_out <= 32'sh7fffffff;
                    else if (r_total < -48'sd2147483648) r_out <= 32'sh80000000;
                    else r_out <= r_total[31:0];
                end
            end
            default: ;
        endcase
    end

    assign o_valid = r_ovalid;
    assign o_vote_sum = r_out;
endmodule
`default_nettype wire

/* tb/tb_boosted_rectangle_feature_classifier.sv */
`default_nettype none
module tb_boosted_rectangle_feature_classifier;

    localparam int IDLE_LIMIT   = 200000;
    localparam int SETTLE_TICKS = 30;

    typedef struct {
        brfc_pkg::t_op      op;
        logic [7:0]         learner;
        logic [1:0]         slot;
        logic [9:0]         ca, cb, cc, cd;
        logic signed [7:0]  rw;
        logic signed [31:0] dv;
        logic               pol;
        logic [2:0]         rc;
        logic signed [15:0] lw;
    } t_brfc_item;

    // Mirror of the classifier tables and the queue of votes still to come out
    class t_vote_scoreboard;
        int          samples [brfc_pkg::SAMPLE_POSITIONS];
        int          corners [brfc_pkg::MAX_LEARNERS*brfc_pkg::MAX_RECTS][4];
        byte         rweights[brfc_pkg::MAX_LEARNERS*brfc_pkg::MAX_RECTS];
        int          thresholds[brfc_pkg::MAX_LEARNERS];
        bit          pols[brfc_pkg::MAX_LEARNERS];
        shortint     lweights[brfc_pkg::MAX_LEARNERS];
        int          rcounts[brfc_pkg::MAX_LEARNERS];
        int          learners_used;
        int          awaited_votes[$];
        int          errors;

        function void set_learners(int v);
            learners_used = v;
        endfunction

        function int strong_vote();
            longint total, resp, box;
            int     n, r, e;
            bit     below, plus;
            total = 0;
            n = (learners_used > brfc_pkg::MAX_LEARNERS) ? brfc_pkg::MAX_LEARNERS
                                                         : learners_used;
            for (int k = 0; k < n; k++) begin
                r = (rcounts[k] > brfc_pkg::MAX_RECTS) ? brfc_pkg::MAX_RECTS : rcounts[k];
                resp = 0;
                for (int j = 0; j < r; j++) begin
                    e = k * brfc_pkg::MAX_RECTS + j;
                    box = longint'(samples[corners[e][0]]) - longint'(samples[corners[e][1]])
                        - longint'(samples[corners[e][2]]) + longint'(samples[corners[e][3]]);
                    resp += longint'(rweights[e]) * box;
                end
                below = resp < longint'(thresholds[k]);
                plus  = pols[k] ? below : !below;
                total += plus ? longint'(lweights[k]) : -longint'(lweights[k]);
            end
            if (total > 64'sd2147483647) total = 64'sd2147483647;
            if (total < -64'sd2147483648) total = -64'sd2147483648;
            return int'(total);
        endfunction

        // Apply one accepted transaction to the mirrored tables
        function void note_item(t_brfc_item it);
            int e;
            e = int'(it.learner) * brfc_pkg::MAX_RECTS + int'(it.slot);
            case (it.op)
                brfc_pkg::OP_LOAD_RECT: begin
                    corners[e][0] = int'(it.ca);
                    corners[e][1] = int'(it.cb);
                    corners[e][2] = int'(it.cc);
                    corners[e][3] = int'(it.cd);
                    rweights[e] = it.rw;
                end
                brfc_pkg::OP_LOAD_LEARNER: begin
                    thresholds[it.learner] = it.dv;
                    pols[it.learner]       = it.pol;
                    lweights[it.learner]   = it.lw;
                    rcounts[it.learner]    = int'(it.rc);
                end
                brfc_pkg::OP_LOAD_SAMPLE: samples[it.ca] = it.dv;
                default: awaited_votes.push_back(strong_vote());
            endcase
        endfunction

        function void check_result(int got);
            int want;
            if (awaited_votes.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result %0d", got);
            end else begin
                want = awaited_votes.pop_front();
                if (want != got) begin
                    errors++;
                    if (errors <= 10)
                        $display("vote_sum mismatch: expected %0d, got %0d", want, got);
                end
            end
        endfunction
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_ready;
    logic [1:0]         i_operation = '0;
    logic [7:0]         i_learner = '0;
    logic [1:0]         i_slot = '0;
    logic [9:0]         i_corner_a = '0, i_corner_b = '0, i_corner_c = '0, i_corner_d = '0;
    logic signed [7:0]  i_rect_weight = '0;
    logic signed [31:0] i_data_value = '0;
    logic               i_polarity = 1'b0;
    logic [2:0]         i_rect_count = '0;
    logic signed [15:0] i_learner_weight = '0;
    logic               i_cfg_we = 1'b0;
    logic [8:0]         i_cfg_data = '0;
    logic               o_valid;
    logic               i_ready = 1'b0;
    logic signed [31:0] o_vote_sum;

    t_vote_scoreboard sb = new();
    bit  calm;
    int  stall_left;
    int  idle_cycles;
    int  known_pos[$];
    bit  pos_known[brfc_pkg::SAMPLE_POSITIONS];
    bit  slot_loaded[brfc_pkg::MAX_LEARNERS*brfc_pkg::MAX_RECTS];

    boosted_rectangle_feature_classifier dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready),
        .i_operation(i_operation), .i_learner(i_learner), .i_slot(i_slot),
        .i_corner_a(i_corner_a), .i_corner_b(i_corner_b),
        .i_corner_c(i_corner_c), .i_corner_d(i_corner_d),
        .i_rect_weight(i_rect_weight), .i_data_value(i_data_value),
        .i_polarity(i_polarity), .i_rect_count(i_rect_count),
        .i_learner_weight(i_learner_weight),
        .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data),
        .o_valid(o_valid), .i_ready(i_ready), .o_vote_sum(o_vote_sum)
    );

    always #5 i_clk = ~i_clk;

    function automatic int pause_len();
        int p;
        p = $urandom_range(0, 99);
        if (calm || p < 60) return 0;
        if (p < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Randomly stall the result channel
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_ready <= 1'b0;
        end else if (!calm && $urandom_range(0, 3) == 0) begin
            stall_left <= pause_len();
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    // Check results and watch for a hang, sampling away from the active edge
    always @(negedge i_clk) begin
        if (o_valid && i_ready) sb.check_result(o_vote_sum);
        if ((i_valid && o_ready) || (o_valid && i_ready)) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Present one transaction, hold it until taken, then pause at random
    task automatic send(t_brfc_item it);
        int gap;
        i_valid          <= 1'b1;
        i_operation      <= it.op;
        i_learner        <= it.learner;
        i_slot           <= it.slot;
        i_corner_a       <= it.ca;
        i_corner_b       <= it.cb;
        i_corner_c       <= it.cc;
        i_corner_d       <= it.cd;
        i_rect_weight    <= it.rw;
        i_data_value     <= it.dv;
        i_polarity       <= it.pol;
        i_rect_count     <= it.rc;
        i_learner_weight <= it.lw;
        do @(negedge i_clk); while (!o_ready);
        sb.note_item(it);
        if (it.op == brfc_pkg::OP_LOAD_SAMPLE && !pos_known[it.ca]) begin
            pos_known[it.ca] = 1'b1;
            known_pos.push_back(int'(it.ca));
        end
        if (it.op == brfc_pkg::OP_LOAD_RECT)
            slot_loaded[int'(it.learner)*brfc_pkg::MAX_RECTS + int'(it.slot)] = 1'b1;
        @(posedge i_clk);
        gap = pause_len();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (sb.awaited_votes.size() != 0) @(posedge i_clk);
        repeat (SETTLE_TICKS) @(posedge i_clk);
    endtask

    task automatic write_learners(int v);
        drain();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v[8:0];
        sb.set_learners(v);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic t_brfc_item noise();
        t_brfc_item it;
        it.op = brfc_pkg::t_op'($urandom_range(0, 3));
        it.learner = 8'($urandom); it.slot = 2'($urandom);
        it.ca = 10'($urandom); it.cb = 10'($urandom);
        it.cc = 10'($urandom); it.cd = 10'($urandom);
        it.rw = 8'($urandom); it.dv = $urandom; it.pol = 1'($urandom);
        it.rc = 3'($urandom); it.lw = 16'($urandom);
        return it;
    endfunction

    function automatic int any_known();
        return known_pos[$urandom_range(0, known_pos.size() - 1)];
    endfunction

    function automatic t_brfc_item rect_load(int lrn, int sl, int a, int b, int c, int d,
                                             int w);
        t_brfc_item it;
        it = noise();
        it.op = brfc_pkg::OP_LOAD_RECT; it.learner = 8'(lrn); it.slot = 2'(sl);
        it.ca = 10'(a); it.cb = 10'(b); it.cc = 10'(c); it.cd = 10'(d); it.rw = 8'(w);
        return it;
    endfunction

    function automatic t_brfc_item learner_load(int lrn, int thr, bit pol, int rc, int lw);
        t_brfc_item it;
        it = noise();
        it.op = brfc_pkg::OP_LOAD_LEARNER; it.learner = 8'(lrn); it.dv = thr;
        it.pol = pol; it.rc = 3'(rc); it.lw = 16'(lw);
        return it;
    endfunction

    function automatic t_brfc_item sample_load(int pos, int v);
        t_brfc_item it;
        it = noise();
        it.op = brfc_pkg::OP_LOAD_SAMPLE; it.ca = 10'(pos); it.dv = v;
        return it;
    endfunction

    function automatic t_brfc_item evaluate();
        t_brfc_item it;
        it = noise();
        it.op = brfc_pkg::OP_EVALUATE;
        return it;
    endfunction

    // Loadable rectangle count: only slots already holding corners may be used
    function automatic int usable_rects(int lrn);
        int s;
        s = 0;
        while (s < brfc_pkg::MAX_RECTS && slot_loaded[lrn*brfc_pkg::MAX_RECTS + s]) s++;
        if (s == brfc_pkg::MAX_RECTS) return $urandom_range(0, 7);
        return $urandom_range(0, s);
    endfunction

    function automatic int random_sample_value();
        case ($urandom_range(0, 9))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2: return 0;
            default: return $urandom;
        endcase
    endfunction

    function automatic t_brfc_item random_item();
        int p, lrn;
        p = $urandom_range(0, 99);
        lrn = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 15) : $urandom_range(0, 255);
        if (p < 30) return sample_load($urandom_range(0, brfc_pkg::SAMPLE_POSITIONS - 1),
                                       random_sample_value());
        if (p < 60) return rect_load(lrn, $urandom_range(0, brfc_pkg::MAX_RECTS - 1),
                                     any_known(), any_known(), any_known(), any_known(),
                                     $urandom);
        if (p < 85) return learner_load(lrn, $urandom, 1'($urandom_range(0, 1)),
                                        usable_rects(lrn), $urandom);
        return evaluate();
    endfunction

    initial begin
        int phase_counts[8] = '{3, 256, 0, 511, 1, 16, 40, 256};
        int n;
        calm = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: no learners, extreme samples, rectangle and learner extremes
        write_learners(0);
        send(evaluate());
        send(sample_load(0, 32'sh7fffffff));
        send(sample_load(brfc_pkg::SAMPLE_POSITIONS - 1, 32'sh80000000));
        send(sample_load(1, -1));
        send(sample_load(2, 0));
        send(sample_load(3, 12345));
        send(rect_load(0, 0, 0, 1023, 1, 2, 127));
        send(rect_load(0, 1, 1023, 0, 0, 1023, -128));
        send(rect_load(0, 2, 3, 2, 1, 0, -1));
        send(rect_load(0, 3, 1023, 1023, 0, 0, 1));
        send(learner_load(0, 32'sh80000000, 1'b1, 7, 32767));
        send(learner_load(1, 32'sh7fffffff, 1'b0, 0, -32768));
        send(learner_load(255, 0, 1'b1, 0, 1));
        write_learners(1);
        send(evaluate());
        write_learners(2);
        send(evaluate());
        send(learner_load(0, 0, 1'b0, 4, -32768));
        send(evaluate());

        // Fill the remaining learners so that every count is evaluable
        calm = 1'b1;
        for (int k = 2; k < brfc_pkg::MAX_LEARNERS - 1; k++)
            send(learner_load(k, $urandom, 1'($urandom_range(0, 1)), 0, $urandom));
        calm = 1'b0;

        // Random phases, each at its own learner count
        foreach (phase_counts[ph]) begin
            n = phase_counts[ph];
            if (ph == 4 || ph == 6) n = $urandom_range(1, 40);
            write_learners(n);
            calm = (ph == 2);
            for (int i = 0; i < 40; i++) send(random_item());
            send(evaluate());
        end
        calm = 1'b0;

        drain();
        if (sb.errors == 0) $display("TB_OK");
        else $display("TB_ERROR");
        $finish;
    end
endmodule
`default_nettype wire
